// File: design/qvr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared defaults, register codes and control types of the vector rotator.
// ----------------------------------------------------------------------------
package qvr_pkg;

  // default widths
  localparam int COORD_WIDTH_DEF    = 32;
  localparam int QUAT_FRAC_BITS_DEF = 30;

  // configuration register index
  localparam int CFG_IDX_WIDTH = 2;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_QUAT_X = 2'd0,
    REG_QUAT_Y = 2'd1,
    REG_QUAT_Z = 2'd2,
    REG_QUAT_W = 2'd3
  } qvr_reg_t;

  // control that travels with each item between units
  typedef struct packed {
    logic valid;
    logic zero_norm;
  } qvr_ctl_t;

endpackage

// File: design/qvr_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_matrix
// Two-stage expansion of the quaternion into the rotation matrix and the
// squared norm. The inverse flag flips the sign of the w-cross terms.
// ----------------------------------------------------------------------------
module qvr_matrix #(
  parameter int CW = 32,
  parameter int QW = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_inverse,
  input  logic signed [CW-1:0]     in_vec_x,
  input  logic signed [CW-1:0]     in_vec_y,
  input  logic signed [CW-1:0]     in_vec_z,
  input  logic signed [QW-1:0]     quat_x,
  input  logic signed [QW-1:0]     quat_y,
  input  logic signed [QW-1:0]     quat_z,
  input  logic signed [QW-1:0]     quat_w,
  output qvr_pkg::qvr_ctl_t        out_ctl,
  output logic signed [2*QW+1:0]   out_m [9],
  output logic [2*QW:0]            out_norm,
  output logic signed [CW-1:0]     out_vec_x,
  output logic signed [CW-1:0]     out_vec_y,
  output logic signed [CW-1:0]     out_vec_z
);
  import qvr_pkg::*;

  localparam int PW = 2 * QW;
  localparam int MW = 2 * QW + 2;
  localparam int NW = 2 * QW + 1;

  // stage 1: component products
  logic                 vld1_r;
  logic                 inv1_r;
  logic signed [CW-1:0] vx1_r, vy1_r, vz1_r;
  logic signed [PW-1:0] xx_r, yy_r, zz_r, ww_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld1_r <= 1'b0;
    else        vld1_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    inv1_r <= in_inverse;
    vx1_r  <= in_vec_x;
    vy1_r  <= in_vec_y;
    vz1_r  <= in_vec_z;
    xx_r   <= quat_x * quat_x;
    yy_r   <= quat_y * quat_y;
    zz_r   <= quat_z * quat_z;
    ww_r   <= quat_w * quat_w;
    xy_r   <= quat_x * quat_y;
    xz_r   <= quat_x * quat_z;
    yz_r   <= quat_y * quat_z;
    wx_r   <= quat_w * quat_x;
    wy_r   <= quat_w * quat_y;
    wz_r   <= quat_w * quat_z;
  end

  // stage 2: matrix entries and norm
  logic signed [MW-1:0] m_nxt [9];
  logic signed [MW-1:0] t1, t2, t3, t5, t6, t7;
  logic [NW-1:0]        norm_nxt;

  always_comb begin
    // conjugate: w-cross terms change sign
    if (inv1_r) begin
      t1 = MW'(xy_r) + MW'(wz_r);
      t2 = MW'(xz_r) - MW'(wy_r);
      t3 = MW'(xy_r) - MW'(wz_r);
      t5 = MW'(yz_r) + MW'(wx_r);
      t6 = MW'(xz_r) + MW'(wy_r);
      t7 = MW'(yz_r) - MW'(wx_r);
    end else begin
      t1 = MW'(xy_r) - MW'(wz_r);
      t2 = MW'(xz_r) + MW'(wy_r);
      t3 = MW'(xy_r) + MW'(wz_r);
      t5 = MW'(yz_r) - MW'(wx_r);
      t6 = MW'(xz_r) - MW'(wy_r);
      t7 = MW'(yz_r) + MW'(wx_r);
    end
    m_nxt[0] = MW'(ww_r) + MW'(xx_r) - MW'(yy_r) - MW'(zz_r);
    m_nxt[1] = t1 <<< 1;
    m_nxt[2] = t2 <<< 1;
    m_nxt[3] = t3 <<< 1;
    m_nxt[4] = MW'(ww_r) - MW'(xx_r) + MW'(yy_r) - MW'(zz_r);
    m_nxt[5] = t5 <<< 1;
    m_nxt[6] = t6 <<< 1;
    m_nxt[7] = t7 <<< 1;
    m_nxt[8] = MW'(ww_r) - MW'(xx_r) - MW'(yy_r) + MW'(zz_r);
    norm_nxt = NW'($unsigned(ww_r)) + NW'($unsigned(xx_r))
             + NW'($unsigned(yy_r)) + NW'($unsigned(zz_r));
  end

  logic vld2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld2_r <= 1'b0;
    else        vld2_r <= vld1_r;
  end

  always_ff @(posedge clk) begin
    out_m     <= m_nxt;
    out_norm  <= norm_nxt;
    out_vec_x <= vx1_r;
    out_vec_y <= vy1_r;
    out_vec_z <= vz1_r;
  end

  assign out_ctl.valid     = vld2_r;
  assign out_ctl.zero_norm = (out_norm == '0);

endmodule

// File: design/qvr_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_mac
// Three-stage matrix-vector product: split partial products, recombine,
// then row sums.
// ----------------------------------------------------------------------------
module qvr_mac #(
  parameter int CW = 32,
  parameter int QW = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  qvr_pkg::qvr_ctl_t         in_ctl,
  input  logic signed [2*QW+1:0]    in_m [9],
  input  logic [2*QW:0]             in_norm,
  input  logic signed [CW-1:0]      in_vec_x,
  input  logic signed [CW-1:0]      in_vec_y,
  input  logic signed [CW-1:0]      in_vec_z,
  output qvr_pkg::qvr_ctl_t         out_ctl,
  output logic signed [2*QW+CW+1:0] out_acc [3],
  output logic [2*QW:0]             out_norm
);
  import qvr_pkg::*;

  localparam int MW  = 2 * QW + 2;
  localparam int MH  = MW / 2;
  localparam int HW  = MW - MH;
  localparam int LPW = MH + 1 + CW;
  localparam int HPW = HW + CW;
  localparam int PW  = MW + CW;
  localparam int NW  = 2 * QW + 1;

  logic signed [CW-1:0] vin [3];
  assign vin[0] = in_vec_x;
  assign vin[1] = in_vec_y;
  assign vin[2] = in_vec_z;

  // stage 3: low and high partial products
  logic signed [LPW-1:0] lo_nxt [9];
  logic signed [HPW-1:0] hi_nxt [9];
  logic signed [LPW-1:0] lo_r [9];
  logic signed [HPW-1:0] hi_r [9];

  always_comb begin
    for (int j = 0; j < 9; j++) begin
      lo_nxt[j] = $signed({1'b0, in_m[j][MH-1:0]}) * vin[j % 3];
      hi_nxt[j] = $signed(in_m[j][MW-1:MH]) * vin[j % 3];
    end
  end

  qvr_ctl_t      ctl3_r, ctl4_r, ctl5_r;
  logic [NW-1:0] norm3_r, norm4_r, norm5_r;

  // control and norm ride along; only the valid bits are reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl3_r.valid <= 1'b0;
      ctl4_r.valid <= 1'b0;
      ctl5_r.valid <= 1'b0;
    end else begin
      ctl3_r.valid <= in_ctl.valid;
      ctl4_r.valid <= ctl3_r.valid;
      ctl5_r.valid <= ctl4_r.valid;
    end
    ctl3_r.zero_norm <= in_ctl.zero_norm;
    ctl4_r.zero_norm <= ctl3_r.zero_norm;
    ctl5_r.zero_norm <= ctl4_r.zero_norm;
  end

  always_ff @(posedge clk) begin
    norm3_r <= in_norm;
    norm4_r <= norm3_r;
    norm5_r <= norm4_r;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
  end

  // stage 4: recombine halves
  logic signed [PW-1:0] p_nxt [9];
  logic signed [PW-1:0] p_r [9];

  always_comb begin
    for (int j = 0; j < 9; j++) begin
      p_nxt[j] = (PW'(hi_r[j]) <<< MH) + PW'(lo_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

  // stage 5: row sums
  logic signed [PW-1:0] acc_nxt [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc_nxt[r] = p_r[3*r] + p_r[3*r+1] + p_r[3*r+2];
    end
  end

  always_ff @(posedge clk) begin
    out_acc <= acc_nxt;
  end

  assign out_ctl  = ctl5_r;
  assign out_norm = norm5_r;

endmodule

// File: design/qvr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_div
// Pipelined restoring divider for one coordinate: round half away from zero,
// saturate to the coordinate range. One quotient bit per stage.
// ----------------------------------------------------------------------------
module qvr_div #(
  parameter int CW = 32,
  parameter int QW = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  qvr_pkg::qvr_ctl_t         in_ctl,
  input  logic signed [2*QW+CW+1:0] in_num,
  input  logic [2*QW:0]             in_den,
  output qvr_pkg::qvr_ctl_t         out_ctl,
  output logic signed [CW-1:0]      out_res,
  output logic                      out_ovf
);
  import qvr_pkg::*;

  localparam int AW  = 2 * QW + CW + 2;
  localparam int NW  = 2 * QW + 1;
  localparam int RW  = AW + 2;
  localparam int DW  = NW + 1;
  localparam int LST = CW + 1;

  // per-stage state; stage 0 is the prep register
  logic          vld_r  [LST+1];
  logic          zero_r [LST+1];
  logic          neg_r  [LST+1];
  logic [RW-1:0] rem_r  [LST+1];
  logic [DW-1:0] d2_r   [LST+1];
  logic          ovf_r  [1:LST];
  logic [CW-1:0] q_r    [1:LST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= LST; s++) vld_r[s] <= 1'b0;
    end else begin
      vld_r[0] <= in_ctl.valid;
      for (int s = 1; s <= LST; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  // prep: magnitude, doubled numerator plus divisor, doubled divisor
  logic signed [RW-1:0] num_ext;
  logic [RW-1:0]        mag;

  always_comb begin
    num_ext = RW'(in_num);
    mag     = in_num[AW-1] ? $unsigned(-num_ext) : $unsigned(num_ext);
  end

  always_ff @(posedge clk) begin
    zero_r[0] <= in_ctl.zero_norm;
    neg_r[0]  <= in_num[AW-1];
    rem_r[0]  <= (mag << 1) + RW'(in_den);
    d2_r[0]   <= {in_den, 1'b0};
  end

  // saturation check against limit times divisor
  logic [RW-1:0] lim_d;
  logic          ovf_nxt;

  always_comb begin
    lim_d   = RW'(d2_r[0]) << (CW - 1);
    ovf_nxt = neg_r[0] ? (rem_r[0] >= lim_d + RW'(d2_r[0])) : (rem_r[0] >= lim_d);
  end

  always_ff @(posedge clk) begin
    zero_r[1] <= zero_r[0];
    neg_r[1]  <= neg_r[0];
    rem_r[1]  <= rem_r[0];
    d2_r[1]   <= d2_r[0];
    ovf_r[1]  <= ovf_nxt;
    q_r[1]    <= '0;
  end

  // quotient bit stages, most significant first
  for (genvar k = 0; k < CW; k++) begin : g_step
    logic [RW-1:0] trial;
    logic          ge;

    always_comb begin
      trial = RW'(d2_r[k+1]) << (CW - 1 - k);
      ge    = (rem_r[k+1] >= trial);
    end

    if (k < CW - 1) begin : g_mid
      always_ff @(posedge clk) begin
        zero_r[k+2] <= zero_r[k+1];
        neg_r[k+2]  <= neg_r[k+1];
        rem_r[k+2]  <= ge ? rem_r[k+1] - trial : rem_r[k+1];
        d2_r[k+2]   <= d2_r[k+1];
        ovf_r[k+2]  <= ovf_r[k+1];
        q_r[k+2]    <= {q_r[k+1][CW-2:0], ge};
      end
    end else begin : g_last
      always_ff @(posedge clk) begin
        zero_r[k+2] <= zero_r[k+1];
        neg_r[k+2]  <= neg_r[k+1];
        rem_r[k+2]  <= rem_r[k+1];
        d2_r[k+2]   <= d2_r[k+1];
        ovf_r[k+2]  <= ovf_r[k+1];
        q_r[k+2]    <= {q_r[k+1][CW-2:0], ge};
      end
    end
  end

  // final sign, saturation and zero-norm override
  localparam logic [CW-1:0] RES_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] RES_MAX = {1'b0, {(CW-1){1'b1}}};

  logic [CW-1:0] res_nxt;
  logic          ovf_out_nxt;
  logic          res_vld_r;
  logic          res_zero_r;

  always_comb begin
    if (zero_r[LST]) begin
      res_nxt     = '0;
      ovf_out_nxt = 1'b0;
    end else if (ovf_r[LST]) begin
      res_nxt     = neg_r[LST] ? RES_MIN : RES_MAX;
      ovf_out_nxt = 1'b1;
    end else begin
      res_nxt     = neg_r[LST] ? (~q_r[LST] + 1'b1) : q_r[LST];
      ovf_out_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) res_vld_r <= 1'b0;
    else        res_vld_r <= vld_r[LST];
  end

  always_ff @(posedge clk) begin
    res_zero_r <= zero_r[LST];
    out_res    <= $signed(res_nxt);
    out_ovf    <= ovf_out_nxt;
  end

  assign out_ctl.valid     = res_vld_r;
  assign out_ctl.zero_norm = res_zero_r;

  // a zero norm never reports saturation
  a_zero_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_ctl.valid && out_ctl.zero_norm |-> !out_ovf && out_res == '0)
    else $error("zero norm result not cleared");

  // saturated results sit on a range bound
  a_ovf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ctl.valid && out_ovf |-> out_res == $signed(RES_MIN) || out_res == $signed(RES_MAX))
    else $error("saturated result off bound");

  // the prep flag reaches the output through every quotient stage and the output register
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] |-> ##(LST+1) out_ctl.valid)
    else $error("divider item lost");

endmodule

// File: design/quaternion_vector_rotator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_vector_rotator
// Rotates Q16.16 vectors by a configured Q2.30 quaternion, normalized by the
// squared quaternion norm, with rounding and saturation.
// ----------------------------------------------------------------------------
// A vector is taken on every cycle with start high and busy low; busy is low
// at all times after reset. Each result appears on the out_ ports for one
// cycle with out_valid, and cannot be held off. The divider resolves one
// quotient bit per pipeline stage; two stages build the matrix and three
// form the matrix-vector product. Write the quaternion with cfg_valid only
// when no vector is in flight; cfg_ready is always high.
// ----------------------------------------------------------------------------
module quaternion_vector_rotator #(
  parameter int COORD_WIDTH    = qvr_pkg::COORD_WIDTH_DEF,
  parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [COORD_WIDTH-1:0]       in_vec_x,
  input  logic signed [COORD_WIDTH-1:0]       in_vec_y,
  input  logic signed [COORD_WIDTH-1:0]       in_vec_z,
  input  logic                                in_inverse,
  output logic                                out_valid,
  output logic signed [COORD_WIDTH-1:0]       out_res_x,
  output logic signed [COORD_WIDTH-1:0]       out_res_y,
  output logic signed [COORD_WIDTH-1:0]       out_res_z,
  output logic                                out_overflow,
  output logic                                out_zero_norm,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [qvr_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
  input  logic [QUAT_FRAC_BITS+1:0]           cfg_data
);
  import qvr_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int QW  = QUAT_FRAC_BITS + 2;
  localparam int MW  = 2 * QW + 2;
  localparam int NW  = 2 * QW + 1;
  localparam int AW  = 2 * QW + CW + 2;
  localparam int LAT = CW + 8;

  // handshake
  logic busy_r;
  logic in_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) busy_r <= 1'b1;
    else        busy_r <= 1'b0;
  end

  assign busy      = busy_r;
  assign cfg_ready = 1'b1;
  assign in_acc    = start && !busy_r;

  // quaternion registers
  logic signed [QW-1:0] quat_x_r, quat_y_r, quat_z_r, quat_w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quat_x_r <= '0;
      quat_y_r <= '0;
      quat_z_r <= '0;
      quat_w_r <= QW'(1) << QUAT_FRAC_BITS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (qvr_reg_t'(cfg_index))
        REG_QUAT_X: quat_x_r <= $signed(cfg_data);
        REG_QUAT_Y: quat_y_r <= $signed(cfg_data);
        REG_QUAT_Z: quat_z_r <= $signed(cfg_data);
        REG_QUAT_W: quat_w_r <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // matrix expansion
  qvr_ctl_t             mat_ctl;
  logic signed [MW-1:0] mat_m [9];
  logic [NW-1:0]        mat_norm;
  logic signed [CW-1:0] mat_vx, mat_vy, mat_vz;

  qvr_matrix #(.CW(CW), .QW(QW)) u_matrix (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_acc),
    .in_inverse (in_inverse),
    .in_vec_x   (in_vec_x),
    .in_vec_y   (in_vec_y),
    .in_vec_z   (in_vec_z),
    .quat_x     (quat_x_r),
    .quat_y     (quat_y_r),
    .quat_z     (quat_z_r),
    .quat_w     (quat_w_r),
    .out_ctl    (mat_ctl),
    .out_m      (mat_m),
    .out_norm   (mat_norm),
    .out_vec_x  (mat_vx),
    .out_vec_y  (mat_vy),
    .out_vec_z  (mat_vz)
  );

  // matrix-vector product
  qvr_ctl_t             mac_ctl;
  logic signed [AW-1:0] mac_acc [3];
  logic [NW-1:0]        mac_norm;

  qvr_mac #(.CW(CW), .QW(QW)) u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ctl   (mat_ctl),
    .in_m     (mat_m),
    .in_norm  (mat_norm),
    .in_vec_x (mat_vx),
    .in_vec_y (mat_vy),
    .in_vec_z (mat_vz),
    .out_ctl  (mac_ctl),
    .out_acc  (mac_acc),
    .out_norm (mac_norm)
  );

  // one divider lane per coordinate
  qvr_ctl_t             lane_ctl [3];
  logic signed [CW-1:0] lane_res [3];
  logic                 lane_ovf [3];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    qvr_div #(.CW(CW), .QW(QW)) u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_ctl  (mac_ctl),
      .in_num  (mac_acc[i]),
      .in_den  (mac_norm),
      .out_ctl (lane_ctl[i]),
      .out_res (lane_res[i]),
      .out_ovf (lane_ovf[i])
    );
  end

  assign out_valid     = lane_ctl[0].valid;
  assign out_res_x     = lane_res[0];
  assign out_res_y     = lane_res[1];
  assign out_res_z     = lane_res[2];
  assign out_overflow  = lane_ovf[0] || lane_ovf[1] || lane_ovf[2];
  assign out_zero_norm = lane_ctl[0].zero_norm;

  // lanes stay in lockstep
  a_lanes_sync: assert property (@(posedge clk) disable iff (!rst_n)
    lane_ctl[0].valid == lane_ctl[1].valid && lane_ctl[0].valid == lane_ctl[2].valid)
    else $error("divider lanes out of step");

  // every accepted vector yields a result, and every result comes from an accepted vector
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##LAT out_valid)
    else $error("result missing");

  a_out_from_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_acc, LAT))
    else $error("result without transfer");

  // zero norm comes only from an all-zero quaternion; its result is cleared, with no overflow
  a_zero_quat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_norm |-> !out_overflow && out_res_x == '0 && out_res_y == '0
      && out_res_z == '0)
    else $error("zero norm result not cleared");

endmodule
